// ===== design/tsbm_pkg.sv =====
// shared types and constants for the token sequence boost memory
package tsbm_pkg;

    // field widths fixed by the stream format
    localparam int TOKEN_W   = 16;
    localparam int PROB_W    = 16;
    localparam int VALUE_W   = 32;
    localparam int TOTAL_W   = 40;
    localparam int QUOT_W    = 17;
    localparam int IDX_W     = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int S_DATA_W  = 96;
    localparam int M_DATA_W  = 24;

    localparam logic [15:0] DEFAULT_BOOST_RST = 16'd256;

    // input operation codes
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_DECAY = 2'd1,
        OP_CAND  = 2'd2,
        OP_BONUS = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_LONG = 2'd2,
        STAT_MANY = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_ENT,
        S_LEN,
        S_CMP,
        S_FILL_RD,
        S_FILL_WR,
        S_ADD_OUT,
        S_MUL,
        S_ACC,
        S_CO_RD,
        S_CO_DIV,
        S_CO_WAIT,
        S_CO_OUT,
        S_DEC_ENT,
        S_DEC_UPD,
        S_BON_ENT,
        S_BON_UPD
    } state_t;

    // divider request and response
    typedef struct packed {
        logic                 start;
        logic [VALUE_W-1:0]   dividend;
        logic [TOTAL_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [QUOT_W-1:0]    quotient;
    } div_rsp_t;

endpackage

// ===== design/tsbm_div.sv =====
// iterative divider: floor(dividend * 2^16 / divisor), one quotient bit per cycle
module tsbm_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  tsbm_pkg::div_req_t req,
    output tsbm_pkg::div_rsp_t rsp
);
    import tsbm_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [TOTAL_W:0]   rem_reg, rem_next;
    logic [TOTAL_W-1:0] dvs_reg, dvs_next;
    logic [QUOT_W-1:0]  quot_reg, quot_next;
    logic [TOTAL_W:0]   trial;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    // one restoring step per cycle, the first step without a shift
    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        trial     = (cnt_reg == CNT_W'(QUOT_W)) ? rem_reg : {rem_reg[TOTAL_W-1:0], 1'b0};
        if (req.start)
        begin
            cnt_next  = CNT_W'(QUOT_W);
            rem_next  = (TOTAL_W+1)'(req.dividend);
            dvs_next  = req.divisor;
            quot_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = trial - {1'b0, dvs_reg};
                quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// ===== design/token_sequence_boost_memory.sv =====
// Token sequence boost memory. Sequences are streamed in one add request per token; the last
// token merges with an identical stored sequence or fills the lowest free slot (status 1 when
// full, 2 when too long). The last add request of a sequence that fits, every candidate request
// that fits and every bonus request scan the table one entry at a time through a registered
// metadata memory and a token memory read one id per cycle; a decay request walks the table
// one entry at a time as well. A candidate list is emitted after its last request, each result
// normalized by the iterative divider when a valid entry exists and the total is not zero.
// No result appears for requests other than the last of an add run or a candidate run.
// s_tready is high only while the sequencer is idle.
module token_sequence_boost_memory
#(
    parameter int NUM_ENTRIES    = 16,
    parameter int MAX_SEQ_LEN    = 16,
    parameter int MAX_CANDIDATES = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // slave stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // token_id, prob, weight, lifetime, boost, bonus
    input  logic [tsbm_pkg::S_DATA_W-1:0]  s_tdata,
    // operation
    input  logic [1:0]                     s_tuser,
    input  logic                           s_tlast,
    // master stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_prob, cand_index, zero pad
    output logic [tsbm_pkg::M_DATA_W-1:0]  m_tdata,
    // status
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsbm_pkg::PADDR_W-1:0]   paddr,
    input  logic [tsbm_pkg::PDATA_W-1:0]   pwdata,
    output logic [tsbm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import tsbm_pkg::*;

    localparam int EW     = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int ECW    = $clog2(NUM_ENTRIES + 1);
    localparam int SW     = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1;
    localparam int LW     = $clog2(MAX_SEQ_LEN + 1);
    localparam int PCW    = $clog2(MAX_SEQ_LEN + 2);
    localparam int CIW    = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CCW    = $clog2(MAX_CANDIDATES + 2);
    localparam int IAW    = EW + SW;
    localparam int SUMW   = 16 + EW;
    localparam int PRODW  = SUMW + 16;
    localparam int META_W = LW + 33;

    // metadata word: length, weight, life, permanent flag
    localparam int M_WT = LW;
    localparam int M_LF = LW + 16;
    localparam int M_FV = LW + 32;

    // memories
    logic [TOKEN_W-1:0] ids_mem  [2**IAW];
    logic [META_W-1:0]  meta_mem [NUM_ENTRIES];
    logic [TOKEN_W-1:0] pend_mem [MAX_SEQ_LEN];
    logic [VALUE_W-1:0] cand_mem [MAX_CANDIDATES];

    logic [TOKEN_W-1:0] ids_rd_reg;
    logic [META_W-1:0]  meta_rd_reg;
    logic [TOKEN_W-1:0] pend_rd_reg;
    logic [VALUE_W-1:0] cand_rd_reg;

    // memory controls
    logic               ids_we;
    logic [IAW-1:0]     ids_raddr, ids_waddr;
    logic               meta_we;
    logic [EW-1:0]      meta_waddr;
    logic [META_W-1:0]  meta_wdata;
    logic               pend_we;
    logic [SW-1:0]      pend_raddr, pend_waddr;
    logic               cand_we;
    logic [CIW-1:0]     cand_waddr;
    logic [VALUE_W-1:0] cand_wdata;
    logic [SW-1:0]      jn;

    // registers
    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [15:0]        id_reg, id_next;
    logic [15:0]        prob_reg, prob_next;
    logic [15:0]        weight_reg, weight_next;
    logic [15:0]        life_reg, life_next;
    logic [15:0]        boost_reg, boost_next;
    logic [15:0]        bonus_reg, bonus_next;
    logic               last_reg, last_next;
    logic [ECW-1:0]     e_reg, e_next;
    logic [SW-1:0]      j_reg, j_next;
    logic               free_found_reg, free_found_next;
    logic [EW-1:0]      free_reg, free_next;
    logic [META_W-1:0]  meta_reg, meta_next;
    logic [SUMW-1:0]    sum_reg, sum_next;
    logic [PRODW-1:0]   prod_reg, prod_next;
    logic [PCW-1:0]     pend_cnt_reg, pend_cnt_next;
    logic [CCW-1:0]     cand_cnt_reg, cand_cnt_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CCW-1:0]     k_reg, k_next;
    logic               any_reg, any_next;
    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic [NUM_ENTRIES-1:0] hits_reg, hits_next;
    logic [15:0]        dflt_reg, dflt_next;
    status_t            st_reg, st_next;
    logic [15:0]        p_reg, p_next;
    logic               m_valid_reg, m_valid_next;
    logic [15:0]        m_prob_reg, m_prob_next;
    logic [IDX_W-1:0]   m_idx_reg, m_idx_next;
    status_t            m_status_reg, m_status_next;
    logic               m_last_reg, m_last_next;

    // shared decode
    logic               accept, out_free, e_end, e_valid, len_skip, id_eq, j_last;
    logic               fill_last, out_last, pend_room, cand_room;
    logic [EW-1:0]      e_idx;
    logic [LW-1:0]      m_len;
    logic               m_forever, q_forever;
    logic [15:0]        m_weight, q_life;
    logic [15:0]        bsel;
    logic [PRODW:0]     v_wide;
    logic [VALUE_W-1:0] v_sat;
    logic [16:0]        life_sum;
    logic [PCW-1:0]     pend_inc;
    op_t                in_op;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    tsbm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_op     = op_t'(s_tuser);
    assign accept    = s_tvalid && (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_tready;
    assign e_end     = (e_reg == ECW'(NUM_ENTRIES));
    assign e_idx     = e_reg[EW-1:0];
    assign e_valid   = valid_reg[e_idx];
    assign m_len     = meta_reg[LW-1:0];
    assign m_weight  = meta_reg[M_WT +: 16];
    assign m_forever = meta_reg[M_FV];
    assign q_life    = meta_rd_reg[M_LF +: 16];
    assign q_forever = meta_rd_reg[M_FV];
    assign len_skip  = ((op_reg == OP_ADD) &&
                        (PCW'(meta_rd_reg[LW-1:0]) != pend_cnt_reg)) ||
                       ((op_reg == OP_BONUS) && q_forever);
    assign id_eq     = (ids_rd_reg == ((op_reg == OP_ADD) ? pend_rd_reg : id_reg));
    assign j_last    = ((LW'(j_reg) + LW'(1)) == m_len);
    assign fill_last = ((PCW'(j_reg) + PCW'(1)) == pend_cnt_reg);
    assign out_last  = ((k_reg + CCW'(1)) == cand_cnt_reg);
    assign pend_room = (pend_cnt_reg < PCW'(MAX_SEQ_LEN));
    assign cand_room = (cand_cnt_reg < CCW'(MAX_CANDIDATES));
    assign pend_inc  = pend_room ? (pend_cnt_reg + PCW'(1)) : PCW'(MAX_SEQ_LEN + 1);
    assign bsel      = (boost_reg != 16'd0) ? boost_reg : dflt_reg;
    assign v_wide    = (PRODW+1)'(prob_reg) + (PRODW+1)'(prod_reg);
    assign v_sat     = (|v_wide[PRODW:VALUE_W]) ? {VALUE_W{1'b1}} : v_wide[VALUE_W-1:0];
    assign life_sum  = {1'b0, q_life} + {1'b0, bonus_reg};

    // memory read addresses
    assign jn         = (state_reg == S_CMP) ? (j_reg + SW'(1)) :
                        (state_reg == S_FILL_RD) ? j_reg : '0;
    assign ids_raddr  = {e_idx, jn};
    assign pend_raddr = jn;

    // token id memory
    always_ff @(posedge clk)
    begin
        if (ids_we)
        begin
            ids_mem[ids_waddr] <= pend_rd_reg;
        end
        ids_rd_reg <= ids_mem[ids_raddr];
    end

    // entry metadata memory
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rd_reg <= meta_mem[e_idx];
    end

    // pending sequence memory
    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[pend_waddr] <= id_next;
        end
        pend_rd_reg <= pend_mem[pend_raddr];
    end

    // candidate value memory
    always_ff @(posedge clk)
    begin
        if (cand_we)
        begin
            cand_mem[cand_waddr] <= cand_wdata;
        end
        cand_rd_reg <= cand_mem[k_reg[CIW-1:0]];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pend_cnt_reg <= '0;
            cand_cnt_reg <= '0;
            total_reg    <= '0;
            valid_reg    <= '0;
            hits_reg     <= '0;
            dflt_reg     <= DEFAULT_BOOST_RST;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_cnt_reg <= pend_cnt_next;
            cand_cnt_reg <= cand_cnt_next;
            total_reg    <= total_next;
            valid_reg    <= valid_next;
            hits_reg     <= hits_next;
            dflt_reg     <= dflt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        prob_reg       <= prob_next;
        weight_reg     <= weight_next;
        life_reg       <= life_next;
        boost_reg      <= boost_next;
        bonus_reg      <= bonus_next;
        last_reg       <= last_next;
        e_reg          <= e_next;
        j_reg          <= j_next;
        free_found_reg <= free_found_next;
        free_reg       <= free_next;
        meta_reg       <= meta_next;
        sum_reg        <= sum_next;
        prod_reg       <= prod_next;
        k_reg          <= k_next;
        any_reg        <= any_next;
        st_reg         <= st_next;
        p_reg          <= p_next;
        m_prob_reg     <= m_prob_next;
        m_idx_reg      <= m_idx_next;
        m_status_reg   <= m_status_next;
        m_last_reg     <= m_last_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_ADD:
                        begin
                            if (s_tlast)
                            begin
                                state_next = (pend_inc > PCW'(MAX_SEQ_LEN)) ? S_ADD_OUT : S_ENT;
                            end
                        end
                        OP_DECAY: state_next = S_DEC_ENT;
                        OP_CAND:
                        begin
                            if (cand_room)
                            begin
                                state_next = S_ENT;
                            end
                            else if (s_tlast)
                            begin
                                state_next = S_ADD_OUT;
                            end
                        end
                        default: state_next = S_ENT;
                    endcase
                end
            end
            S_ENT:
            begin
                if (e_end)
                begin
                    case (op_reg)
                        OP_ADD:  state_next = free_found_reg ? S_FILL_RD : S_ADD_OUT;
                        OP_CAND: state_next = S_MUL;
                        default: state_next = last_reg ? S_BON_ENT : S_IDLE;
                    endcase
                end
                else if (e_valid)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:     state_next = len_skip ? S_ENT : S_CMP;
            S_CMP:
            begin
                if (op_reg == OP_ADD)
                begin
                    if (!id_eq)
                    begin
                        state_next = S_ENT;
                    end
                    else if (j_last)
                    begin
                        state_next = S_ADD_OUT;
                    end
                end
                else if (id_eq || j_last)
                begin
                    state_next = S_ENT;
                end
            end
            S_FILL_RD: state_next = S_FILL_WR;
            S_FILL_WR: state_next = fill_last ? S_ADD_OUT : S_FILL_RD;
            S_ADD_OUT: state_next = out_free ? S_IDLE : S_ADD_OUT;
            S_MUL:     state_next = S_ACC;
            S_ACC:     state_next = last_reg ? S_CO_RD : S_IDLE;
            S_CO_RD:   state_next = S_CO_DIV;
            S_CO_DIV:  state_next = (any_reg && (total_reg != '0)) ? S_CO_WAIT : S_CO_OUT;
            S_CO_WAIT: state_next = div_rsp.done ? S_CO_OUT : S_CO_WAIT;
            S_CO_OUT:
            begin
                if (out_free)
                begin
                    state_next = out_last ? S_IDLE : S_CO_RD;
                end
            end
            S_DEC_ENT:
            begin
                if (e_end)
                begin
                    state_next = S_IDLE;
                end
                else if (e_valid)
                begin
                    state_next = S_DEC_UPD;
                end
            end
            S_DEC_UPD: state_next = S_DEC_ENT;
            S_BON_ENT:
            begin
                if (e_end)
                begin
                    state_next = S_IDLE;
                end
                else if ((bonus_reg != 16'd0) && hits_reg[e_idx] && e_valid)
                begin
                    state_next = S_BON_UPD;
                end
            end
            S_BON_UPD: state_next = S_BON_ENT;
            default:   state_next = S_IDLE;
        endcase
    end

    // register updates and memory controls
    always_comb
    begin
        op_next         = op_reg;
        id_next         = id_reg;
        prob_next       = prob_reg;
        weight_next     = weight_reg;
        life_next       = life_reg;
        boost_next      = boost_reg;
        bonus_next      = bonus_reg;
        last_next       = last_reg;
        e_next          = e_reg;
        j_next          = j_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        meta_next       = meta_reg;
        sum_next        = sum_reg;
        prod_next       = prod_reg;
        pend_cnt_next   = pend_cnt_reg;
        cand_cnt_next   = cand_cnt_reg;
        total_next      = total_reg;
        k_next          = k_reg;
        any_next        = any_reg;
        valid_next      = valid_reg;
        hits_next       = hits_reg;
        dflt_next       = dflt_reg;
        st_next         = st_reg;
        p_next          = p_reg;
        m_valid_next    = m_tready ? 1'b0 : m_valid_reg;
        m_prob_next     = m_prob_reg;
        m_idx_next      = m_idx_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;
        ids_we          = 1'b0;
        ids_waddr       = {free_reg, j_reg};
        meta_we         = 1'b0;
        meta_waddr      = e_idx;
        meta_wdata      = meta_reg;
        pend_we         = 1'b0;
        pend_waddr      = pend_cnt_reg[SW-1:0];
        cand_we         = 1'b0;
        cand_waddr      = cand_cnt_reg[CIW-1:0];
        cand_wdata      = v_sat;
        div_req.start    = 1'b0;
        div_req.dividend = cand_rd_reg;
        div_req.divisor  = total_reg;

        // configuration write
        if (psel && penable && pwrite && !paddr[2])
        begin
            dflt_next = pwdata[15:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = in_op;
                    id_next         = s_tdata[15:0];
                    prob_next       = s_tdata[31:16];
                    weight_next     = s_tdata[47:32];
                    life_next       = s_tdata[63:48];
                    boost_next      = s_tdata[79:64];
                    bonus_next      = s_tdata[95:80];
                    last_next       = s_tlast;
                    e_next          = '0;
                    sum_next        = '0;
                    free_found_next = 1'b0;
                    case (in_op)
                        OP_ADD:
                        begin
                            pend_we       = pend_room;
                            pend_cnt_next = pend_inc;
                            st_next       = STAT_LONG;
                        end
                        OP_CAND:
                        begin
                            if (!cand_room)
                            begin
                                cand_cnt_next = CCW'(MAX_CANDIDATES + 1);
                            end
                            st_next = STAT_MANY;
                        end
                        default: ;
                    endcase
                end
            end
            S_ENT:
            begin
                if (e_end)
                begin
                    j_next  = '0;
                    e_next  = '0;
                    st_next = STAT_FULL;
                    if ((op_reg == OP_BONUS) && !last_reg)
                    begin
                        e_next = '0;
                    end
                end
                else if (!e_valid)
                begin
                    if ((op_reg == OP_ADD) && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_next       = e_idx;
                    end
                    e_next = e_reg + ECW'(1);
                end
            end
            S_LEN:
            begin
                meta_next = meta_rd_reg;
                j_next    = '0;
                if (len_skip)
                begin
                    e_next = e_reg + ECW'(1);
                end
            end
            S_CMP:
            begin
                if (op_reg == OP_ADD)
                begin
                    if (!id_eq)
                    begin
                        e_next = e_reg + ECW'(1);
                    end
                    else if (j_last)
                    begin
                        // merge with the matching entry
                        meta_we    = 1'b1;
                        meta_wdata = meta_reg;
                        if (!m_forever)
                        begin
                            meta_wdata[M_LF +: 16] = life_reg;
                            meta_wdata[M_FV]       = (life_reg == 16'd0);
                        end
                        if (weight_reg > m_weight)
                        begin
                            meta_wdata[M_WT +: 16] = weight_reg;
                        end
                        st_next = STAT_OK;
                    end
                    else
                    begin
                        j_next = j_reg + SW'(1);
                    end
                end
                else if (id_eq)
                begin
                    if (op_reg == OP_CAND)
                    begin
                        sum_next = sum_reg + SUMW'(m_weight);
                    end
                    else
                    begin
                        hits_next[e_idx] = 1'b1;
                    end
                    e_next = e_reg + ECW'(1);
                end
                else if (j_last)
                begin
                    e_next = e_reg + ECW'(1);
                end
                else
                begin
                    j_next = j_reg + SW'(1);
                end
            end
            S_FILL_WR:
            begin
                // copy one pending id into the free slot
                ids_we = 1'b1;
                if (fill_last)
                begin
                    meta_we    = 1'b1;
                    meta_waddr = free_reg;
                    meta_wdata = {(life_reg == 16'd0), life_reg, weight_reg,
                                  pend_cnt_reg[LW-1:0]};
                    valid_next[free_reg] = 1'b1;
                    hits_next[free_reg]  = 1'b0;
                    st_next = STAT_OK;
                end
                else
                begin
                    j_next = j_reg + SW'(1);
                end
            end
            S_ADD_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_prob_next   = '0;
                    m_idx_next    = '0;
                    m_status_next = st_reg;
                    m_last_next   = 1'b1;
                    if (op_reg == OP_ADD)
                    begin
                        pend_cnt_next = '0;
                    end
                    else
                    begin
                        cand_cnt_next = '0;
                        total_next    = '0;
                    end
                end
            end
            S_MUL:
            begin
                prod_next = PRODW'(bsel) * PRODW'(sum_reg);
            end
            S_ACC:
            begin
                cand_we       = 1'b1;
                total_next    = total_reg + TOTAL_W'(v_sat);
                cand_cnt_next = cand_cnt_reg + CCW'(1);
                k_next        = '0;
                any_next      = |valid_reg;
            end
            S_CO_DIV:
            begin
                if (any_reg && (total_reg != '0))
                begin
                    div_req.start = 1'b1;
                end
                else
                begin
                    p_next = (|cand_rd_reg[VALUE_W-1:16]) ? 16'hFFFF : cand_rd_reg[15:0];
                end
            end
            S_CO_WAIT:
            begin
                if (div_rsp.done)
                begin
                    p_next = div_rsp.quotient[16] ? 16'hFFFF : div_rsp.quotient[15:0];
                end
            end
            S_CO_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_prob_next   = p_reg;
                    m_idx_next    = k_reg[IDX_W-1:0];
                    m_status_next = STAT_OK;
                    m_last_next   = out_last;
                    k_next        = k_reg + CCW'(1);
                    if (out_last)
                    begin
                        cand_cnt_next = '0;
                        total_next    = '0;
                    end
                end
            end
            S_DEC_ENT:
            begin
                if (!e_end && !e_valid)
                begin
                    e_next = e_reg + ECW'(1);
                end
            end
            S_DEC_UPD:
            begin
                // count down a live lifetime, free on expiry
                if (!q_forever && (q_life != 16'd0))
                begin
                    meta_we                = 1'b1;
                    meta_wdata             = meta_rd_reg;
                    meta_wdata[M_LF +: 16] = q_life - 16'd1;
                    if (q_life == 16'd1)
                    begin
                        valid_next[e_idx] = 1'b0;
                    end
                end
                e_next = e_reg + ECW'(1);
            end
            S_BON_ENT:
            begin
                if (e_end)
                begin
                    hits_next = '0;
                end
                else if (!((bonus_reg != 16'd0) && hits_reg[e_idx] && e_valid))
                begin
                    e_next = e_reg + ECW'(1);
                end
            end
            S_BON_UPD:
            begin
                // saturating lifetime extension
                if (!q_forever)
                begin
                    meta_we                = 1'b1;
                    meta_wdata             = meta_rd_reg;
                    meta_wdata[M_LF +: 16] = life_sum[16] ? 16'hFFFF : life_sum[15:0];
                end
                e_next = e_reg + ECW'(1);
            end
            default: ;
        endcase
    end

    // port outputs
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_idx_reg, m_prob_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? '0 : {16'd0, dflt_reg};

endmodule

// ===== tb/sv/token_sequence_boost_memory_test.sv =====
// self-checking stream testbench for the token sequence boost memory
module token_sequence_boost_memory_test;
    import tsbm_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int SEQ_MAX     = 16;
    localparam int CAND_MAX    = 32;
    localparam int SETTLE      = 600;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [15:0] prob;
        logic [4:0]  index;
        status_t     status;
        logic        last;
    } result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // token_id, prob, weight, lifetime, boost, bonus
    logic [S_DATA_W-1:0]   s_tdata;
    // operation
    logic [1:0]            s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    // out_prob, cand_index, zero pad
    logic [M_DATA_W-1:0]   m_tdata;
    // status
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    // predicted block state
    logic [15:0] seq_ids [ENTRIES][SEQ_MAX];
    int          seq_len [ENTRIES];
    logic [15:0] seq_weight [ENTRIES];
    logic [15:0] seq_life [ENTRIES];
    bit          seq_permanent [ENTRIES];
    bit          seq_valid [ENTRIES];
    bit          bonus_mark [ENTRIES];
    logic [15:0] pending_tokens [SEQ_MAX];
    int          pending_len;
    logic [31:0] boosted [CAND_MAX];
    int          boosted_count;
    logic [63:0] boosted_total;
    logic [15:0] boost_default;

    result_t expected_results [$];
    int      error_count;
    int      sent_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_idle_pct;

    token_sequence_boost_memory DUT (.*);

    // clock and cycle limit
    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // result checker, samples mid-cycle ahead of the accepting edge
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $error("unexpected result out_prob=%0d", m_tdata[15:0]);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[15:0] !== want.prob)
                begin
                    error_count++;
                    $error("out_prob expected %0d actual %0d", want.prob, m_tdata[15:0]);
                end
                if (m_tdata[20:16] !== want.index)
                begin
                    error_count++;
                    $error("cand_index expected %0d actual %0d", want.index, m_tdata[20:16]);
                end
                if (m_tuser !== want.status)
                begin
                    error_count++;
                    $error("status expected %0d actual %0d", want.status, m_tuser);
                end
                if (m_tlast !== want.last)
                begin
                    error_count++;
                    $error("last_out expected %0d actual %0d", want.last, m_tlast);
                end
            end
        end
    end

    function automatic bit entry_has(int e, logic [15:0] id);
        for (int j = 0; j < seq_len[e] && j < SEQ_MAX; j++)
            if (seq_ids[e][j] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit entry_equals_pending(int e);
        if (seq_len[e] != pending_len)
            return 1'b0;
        for (int j = 0; j < pending_len; j++)
            if (seq_ids[e][j] != pending_tokens[j])
                return 1'b0;
        return 1'b1;
    endfunction

    // merge or store the pending sequence
    function automatic status_t store_sequence(logic [15:0] wt, logic [15:0] life);
        if (pending_len > SEQ_MAX)
            return STAT_LONG;
        for (int e = 0; e < ENTRIES; e++)
        begin
            if (seq_valid[e] && entry_equals_pending(e))
            begin
                if (!seq_permanent[e])
                begin
                    seq_life[e] = life;
                    seq_permanent[e] = (life == 0);
                end
                if (wt > seq_weight[e])
                    seq_weight[e] = wt;
                return STAT_OK;
            end
        end
        for (int e = 0; e < ENTRIES; e++)
        begin
            if (!seq_valid[e])
            begin
                for (int j = 0; j < pending_len; j++)
                    seq_ids[e][j] = pending_tokens[j];
                seq_len[e] = pending_len;
                seq_weight[e] = wt;
                seq_life[e] = life;
                seq_permanent[e] = (life == 0);
                seq_valid[e] = 1'b1;
                bonus_mark[e] = 1'b0;
                return STAT_OK;
            end
        end
        return STAT_FULL;
    endfunction

    function automatic void push_result(logic [15:0] p, int k, status_t st, logic lo);
        result_t r;
        r.prob = p;
        r.index = k[4:0];
        r.status = st;
        r.last = lo;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // predict the results of one accepted request
    function automatic void predict(op_t op, logic [15:0] id, logic [15:0] prob,
                                    logic [15:0] wt, logic [15:0] life,
                                    logic [15:0] bst, logic [15:0] bon, logic lst);
        logic [63:0] b;
        logic [63:0] sum;
        logic [63:0] v;
        logic [63:0] p;
        logic [31:0] t;
        bit any;
        case (op)
            OP_ADD:
            begin
                if (pending_len < SEQ_MAX)
                    pending_tokens[pending_len++] = id;
                else
                    pending_len = SEQ_MAX + 1;
                if (lst)
                begin
                    push_result(16'd0, 0, store_sequence(wt, life), 1'b1);
                    pending_len = 0;
                end
            end
            OP_DECAY:
            begin
                for (int e = 0; e < ENTRIES; e++)
                begin
                    if (seq_valid[e] && !seq_permanent[e] && seq_life[e] != 0)
                    begin
                        seq_life[e] = seq_life[e] - 1;
                        if (seq_life[e] == 0)
                            seq_valid[e] = 1'b0;
                    end
                end
            end
            OP_CAND:
            begin
                if (boosted_count < CAND_MAX)
                begin
                    b = (bst != 0) ? bst : boost_default;
                    sum = 0;
                    for (int e = 0; e < ENTRIES; e++)
                        if (seq_valid[e] && entry_has(e, id))
                            sum += seq_weight[e];
                    v = prob + b * sum;
                    if (v > 64'hFFFF_FFFF)
                        v = 64'hFFFF_FFFF;
                    boosted[boosted_count++] = v[31:0];
                    boosted_total += v;
                end
                else
                    boosted_count = CAND_MAX + 1;
                if (lst)
                begin
                    if (boosted_count > CAND_MAX)
                        push_result(16'd0, 0, STAT_MANY, 1'b1);
                    else
                    begin
                        any = 1'b0;
                        for (int e = 0; e < ENTRIES; e++)
                            any |= seq_valid[e];
                        for (int k = 0; k < boosted_count; k++)
                        begin
                            p = boosted[k];
                            if (any && boosted_total != 0)
                                p = (p << 16) / boosted_total;
                            if (p > 64'hFFFF)
                                p = 64'hFFFF;
                            push_result(p[15:0], k, STAT_OK, k + 1 == boosted_count);
                        end
                    end
                    boosted_count = 0;
                    boosted_total = 0;
                end
            end
            default:
            begin
                for (int e = 0; e < ENTRIES; e++)
                    if (seq_valid[e] && !seq_permanent[e] && entry_has(e, id))
                        bonus_mark[e] = 1'b1;
                if (lst)
                begin
                    for (int e = 0; e < ENTRIES; e++)
                    begin
                        if (bon != 0 && bonus_mark[e] && seq_valid[e] && !seq_permanent[e])
                        begin
                            t = seq_life[e] + bon;
                            seq_life[e] = (t > 32'hFFFF) ? 16'hFFFF : t[15:0];
                        end
                        bonus_mark[e] = 1'b0;
                    end
                end
            end
        endcase
    endfunction

    // send one request and predict on acceptance
    task automatic send_req(op_t op, logic [15:0] id, logic [15:0] prob, logic [15:0] wt,
                            logic [15:0] life, logic [15:0] bst, logic [15:0] bon, logic lst);
        bit rdy;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bon, bst, life, wt, prob, id};
        s_tuser  <= op;
        s_tlast  <= lst;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        predict(op, id, prob, wt, life, bst, bon, lst);
        sent_count++;
    endtask

    // wait for all results, then let any scan in progress finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_default_boost(logic [15:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= '0;
        pwdata  <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        boost_default = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] pick_token();
        return ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                        : 16'($urandom_range(1, 8));
    endfunction

    function automatic logic [15:0] pick_life();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic add_sequence(int len);
        logic [15:0] wt;
        logic [15:0] life;
        wt = 16'($urandom_range(65535));
        life = pick_life();
        for (int i = 0; i < len; i++)
            send_req(OP_ADD, pick_token(), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 1'b0);
        send_req(OP_ADD, pick_token(), 16'($urandom), wt, life, 16'($urandom),
                 16'($urandom), 1'b1);
    endtask

    task automatic candidate_list(int len);
        logic [15:0] bst;
        for (int i = 0; i < len; i++)
        begin
            bst = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535));
            send_req(OP_CAND, pick_token(), 16'($urandom), 16'($urandom), 16'($urandom),
                     bst, 16'($urandom), i == len - 1);
        end
    endtask

    task automatic bonus_list(int len);
        logic [15:0] bon;
        bon = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535));
        for (int i = 0; i < len; i++)
            send_req(OP_BONUS, pick_token(), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), bon, i == len - 1);
    endtask

    // extremes, every operation, empty table, merge, bonus and decay
    task automatic test_directed();
        // empty table: zero total, then unnormalized values
        send_req(OP_CAND, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_req(OP_CAND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_req(OP_CAND, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        // sequence 1,2,3 with a short life and a permanent sequence 2
        send_req(OP_ADD, 16'd1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
        send_req(OP_ADD, 16'd2, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
        send_req(OP_ADD, 16'd3, 16'h0, 16'h0100, 16'd2, 16'h0, 16'h0, 1'b1);
        send_req(OP_ADD, 16'd2, 16'h0, 16'hFFFF, 16'd0, 16'h0, 16'h0, 1'b1);
        send_req(OP_ADD, 16'hFFFF, 16'h0, 16'h0001, 16'hFFFF, 16'h0, 16'h0, 1'b1);
        // candidates against the table, boost at both extremes and default
        send_req(OP_CAND, 16'd2, 16'hFFFF, 16'h0, 16'h0, 16'hFFFF, 16'h0, 1'b0);
        send_req(OP_CAND, 16'd1, 16'h0000, 16'h0, 16'h0, 16'h0000, 16'h0, 1'b0);
        send_req(OP_CAND, 16'd9, 16'h8000, 16'h0, 16'h0, 16'h0001, 16'h0, 1'b0);
        send_req(OP_CAND, 16'hFFFF, 16'h0001, 16'h0, 16'h0, 16'h0000, 16'h0, 1'b1);
        // merge with a larger weight, then bonus with saturation
        send_req(OP_ADD, 16'd1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
        send_req(OP_ADD, 16'd2, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
        send_req(OP_ADD, 16'd3, 16'h0, 16'h4000, 16'd3, 16'h0, 16'h0, 1'b1);
        send_req(OP_BONUS, 16'd3, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
        send_req(OP_BONUS, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 1'b1);
        send_req(OP_BONUS, 16'd1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0000, 1'b1);
        // decay, then candidates after expiry
        send_req(OP_DECAY, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
        send_req(OP_DECAY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_req(OP_CAND, 16'd3, 16'h1234, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0);
        send_req(OP_CAND, 16'd2, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1);
    endtask

    // overlong sequence, too many candidates, full table
    task automatic test_limits();
        add_sequence(SEQ_MAX + 1);
        add_sequence(SEQ_MAX - 1);
        candidate_list(CAND_MAX + 1);
        candidate_list(CAND_MAX);
        for (int i = 0; i < ENTRIES + 1; i++)
            send_req(OP_ADD, 16'(1000 + i), 16'h0, 16'($urandom), 16'd3, 16'h0, 16'h0, 1'b1);
        for (int i = 0; i < 3; i++)
            send_req(OP_DECAY, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1);
    endtask

    // mostly well-formed runs with random content, some stray requests
    task automatic test_random(int count, bit hold_off);
        int stop;
        stop = sent_count + count;
        while (sent_count < stop)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5:     add_sequence($urandom_range(0, 3));
                6, 7, 8:              send_req(OP_DECAY, 16'($urandom), 16'($urandom),
                                               16'($urandom), 16'($urandom), 16'($urandom),
                                               16'($urandom), 1'($urandom));
                9, 10, 11, 12, 13:    candidate_list($urandom_range(1, 6));
                14, 15:               bonus_list($urandom_range(1, 3));
                16:                   add_sequence(($urandom_range(3) == 0) ? SEQ_MAX + 1
                                                                            : SEQ_MAX - 1);
                17:
                begin
                    candidate_list($urandom_range(1, 4));
                    if (hold_off)
                        drain();
                end
                default:              send_req(op_t'($urandom_range(3)), pick_token(),
                                               16'($urandom), 16'($urandom), pick_life(),
                                               16'($urandom), 16'($urandom), 1'($urandom));
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        sent_count = 0;
        send_idle_pct = 38;
        recv_idle_pct = 46;
        for (int e = 0; e < ENTRIES; e++)
        begin
            seq_len[e] = 0;
            seq_weight[e] = '0;
            seq_life[e] = '0;
            seq_permanent[e] = 1'b0;
            seq_valid[e] = 1'b0;
            bonus_mark[e] = 1'b0;
        end
        pending_len = 0;
        boosted_count = 0;
        boosted_total = '0;
        boost_default = DEFAULT_BOOST_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_default_boost(16'hFFFF);
        test_limits();
        write_default_boost(16'h0000);
        test_random(88, 1'b1);

        send_idle_pct = 46;
        recv_idle_pct = 38;
        write_default_boost(16'($urandom_range(65535)));
        test_random(88, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_default_boost(16'd1);
        test_random(88, 1'b0);

        drain();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
